// ===== rtl/i2c_master_bit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion forms for the bit engine RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication
`define I2CMBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CMBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types and constants shared by the I2C master bit engine modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	typedef enum logic [2:0] {
		ACT_START = 3'd0,
		ACT_STOP  = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_WAIT  = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'd0,
		ST_START0 = 5'd1,
		ST_START1 = 5'd2,
		ST_START2 = 5'd3,
		ST_STOP0  = 5'd4,
		ST_STOP1  = 5'd5,
		ST_STOP2  = 5'd6,
		ST_WAIT0  = 5'd7,
		ST_WAIT1  = 5'd8,
		ST_WAIT2  = 5'd9,
		ST_TX_A   = 5'd10,
		ST_TX_B   = 5'd11,
		ST_TX_C   = 5'd12,
		ST_RX_A   = 5'd13,
		ST_RX_B   = 5'd14,
		ST_AK0    = 5'd15,
		ST_AK1    = 5'd16,
		ST_AK2    = 5'd17,
		ST_AK3    = 5'd18
	} step_t;

	// classified phase word passed from front to back
	typedef struct packed {
		logic       sample;
		logic       cmd_ok;
		step_t      entry_step;
		logic       is_wait;
		logic [7:0] tx_byte;
		logic       send_ack;
	} phase_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic ready_res;
		logic done_res;
		logic [7:0] rx_byte;
		logic ack_missing;
	} result_t;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// A phase word passes through the queue and the sequencer into the output register.
// Throughput: one phase word per cycle while the queue has room; the sequencer steps
// once per cycle with a word queued and the output register free or being drained.
// A two-entry queue lets the input side keep accepting while the output stalls.
// Reset (arst_n low, asynchronous): sequencer idle, SCL and SDA released,
// ack_timeout 250, queue and output register empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: front decode, phase queue, bit sequencer.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       sda_sample,
	input  logic       cmd_valid,
	input  logic [2:0] action,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       ready_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_missing
);
	import i2cmbe_pkg::*;

	phase_t  q_wdata;
	phase_t  q_rdata;
	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_not_empty;
	result_t res;

	i2cmbe_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sda_sample (sda_sample),
		.cmd_valid  (cmd_valid),
		.action     (action),
		.tx_byte    (tx_byte),
		.send_ack   (send_ack),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	i2cmbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	i2cmbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign scl_level   = res.scl_level;
	assign sda_level   = res.sda_level;
	assign ready_res   = res.ready_res;
	assign done_res    = res.done_res;
	assign rx_byte     = res.rx_byte;
	assign ack_missing = res.ack_missing;

endmodule

// ===== rtl/i2cmbe_front.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_front
// Accepts phase words and decodes the offered command into an entry step.
// ----------------------------------------------------------------------------
module i2cmbe_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               sda_sample,
	input  logic               cmd_valid,
	input  logic [2:0]         action,
	input  logic [7:0]         tx_byte,
	input  logic               send_ack,
	input  logic               q_full,
	output logic               q_push,
	output i2cmbe_pkg::phase_t q_wdata
);
	import i2cmbe_pkg::*;

	logic  act_known;
	step_t entry;

	always_comb begin
		act_known = 1'b1;
		case (action)
			ACT_START: entry = ST_START0;
			ACT_STOP:  entry = ST_STOP0;
			ACT_WRITE: entry = ST_TX_A;
			ACT_WAIT:  entry = ST_WAIT0;
			ACT_READ:  entry = ST_RX_A;
			default: begin
				entry     = ST_IDLE;
				act_known = 1'b0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_wdata.sample     = sda_sample;
		q_wdata.cmd_ok     = cmd_valid && act_known;
		q_wdata.entry_step = entry;
		q_wdata.is_wait    = (action == ACT_WAIT);
		q_wdata.tx_byte    = tx_byte;
		q_wdata.send_ack   = send_ack;
	end

endmodule

// ===== rtl/i2cmbe_queue.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_queue
// Two-entry queue of decoded phase words between front and back.
// ----------------------------------------------------------------------------
module i2cmbe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cmbe_pkg::phase_t wdata,
	input  logic               pop,
	output i2cmbe_pkg::phase_t rdata,
	output logic               full,
	output logic               not_empty
);
	import i2cmbe_pkg::*;
	`include "i2c_master_bit_engine_macros.svh"

	phase_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`I2CMBE_ASSERT_IMP(a_q_no_overflow, clk, arst_n, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count over depth")
	`I2CMBE_ASSERT_IMP(a_q_no_underflow, clk, arst_n, pop, not_empty, "pop from empty queue")

endmodule

// ===== rtl/i2cmbe_back.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_back
// Bit sequencer: steps one phase per queued word into an output register.
// ----------------------------------------------------------------------------
module i2cmbe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                q_not_empty,
	input  i2cmbe_pkg::phase_t  q_rdata,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output i2cmbe_pkg::result_t res
);
	import i2cmbe_pkg::*;
	`include "i2c_master_bit_engine_macros.svh"

	step_t      step_q;
	logic [3:0] bc_q;
	logic [7:0] shift_q;
	logic [7:0] wc_q;
	logic       ack_q;
	logic       wait_act_q;
	logic [7:0] held_q;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] to_q;
	logic       out_valid_q;
	result_t    res_q;

	// state after command entry
	logic       start_cmd;
	step_t      step_e;
	logic [3:0] bc_e;
	logic [7:0] shift_e;
	logic       ack_e;
	logic       wait_act_e;
	logic       sda_e;

	step_t      step_d;
	logic [3:0] bc_inc;
	logic [3:0] bc_d;
	logic [7:0] shift_d;
	logic [7:0] wc_d;
	logic [7:0] held_d;
	logic       scl_d;
	logic       sda_d;
	logic       sda_out;
	logic       done;
	logic       missing;

	always_comb begin
		start_cmd  = (step_q == ST_IDLE) && q_rdata.cmd_ok;
		step_e     = step_q;
		bc_e       = bc_q;
		shift_e    = shift_q;
		ack_e      = ack_q;
		wait_act_e = wait_act_q;
		sda_e      = sda_q;
		if (start_cmd) begin
			step_e     = q_rdata.entry_step;
			bc_e       = '0;
			wait_act_e = q_rdata.is_wait;
			if (q_rdata.entry_step == ST_TX_A) shift_e = q_rdata.tx_byte;
			if (q_rdata.entry_step == ST_RX_A) begin
				shift_e = '0;
				ack_e   = q_rdata.send_ack;
				sda_e   = 1'b1;
			end
		end
	end

	assign bc_inc = bc_e + 4'd1;

	// next step
	always_comb begin
		case (step_e)
			ST_START0: step_d = ST_START1;
			ST_START1: step_d = ST_START2;
			ST_STOP0:  step_d = ST_STOP1;
			ST_STOP1:  step_d = ST_STOP2;
			ST_WAIT0:  step_d = ST_WAIT1;
			ST_WAIT1: begin
				if (!q_rdata.sample)  step_d = ST_WAIT2;
				else if (wc_q >= to_q) step_d = ST_STOP0;
				else                   step_d = ST_WAIT1;
			end
			ST_TX_A:   step_d = ST_TX_B;
			ST_TX_B:   step_d = ST_TX_C;
			ST_TX_C:   step_d = bc_inc[3] ? ST_IDLE : ST_TX_A;
			ST_RX_A:   step_d = ST_RX_B;
			ST_RX_B:   step_d = bc_inc[3] ? ST_AK0 : ST_RX_A;
			ST_AK0:    step_d = ST_AK1;
			ST_AK1:    step_d = ST_AK2;
			ST_AK2:    step_d = ack_e ? ST_AK3 : ST_IDLE;
			default:   step_d = ST_IDLE;
		endcase
	end

	// phase outputs and datapath
	always_comb begin
		bc_d    = bc_e;
		shift_d = shift_e;
		wc_d    = wc_q;
		held_d  = held_q;
		scl_d   = scl_q;
		sda_d   = sda_e;
		sda_out = sda_e;
		done    = 1'b0;
		missing = 1'b0;
		case (step_e)
			ST_START0: begin
				sda_d = 1'b1;
				scl_d = 1'b1;
			end
			ST_START1: sda_d = 1'b0;
			ST_START2: begin
				scl_d = 1'b0;
				done  = 1'b1;
			end
			ST_STOP0: sda_d = 1'b0;
			ST_STOP1: scl_d = 1'b1;
			ST_STOP2: begin
				sda_d   = 1'b1;
				done    = 1'b1;
				missing = wait_act_e;
			end
			ST_WAIT0: begin
				sda_d = 1'b1;
				wc_d  = '0;
			end
			ST_WAIT1: begin
				scl_d = 1'b1;
				if (q_rdata.sample && (wc_q < to_q)) wc_d = wc_q + 8'd1;
			end
			ST_WAIT2: begin
				scl_d = 1'b0;
				done  = 1'b1;
			end
			ST_TX_A: begin
				sda_d   = shift_e[7];
				shift_d = {shift_e[6:0], 1'b0};
			end
			ST_TX_B: scl_d = 1'b1;
			ST_TX_C: begin
				scl_d = 1'b0;
				bc_d  = bc_inc;
				if (bc_inc[3]) begin
					sda_d = 1'b1;
					done  = 1'b1;
				end
			end
			ST_RX_A: begin
				scl_d   = 1'b1;
				shift_d = {shift_e[6:0], q_rdata.sample};
			end
			ST_RX_B: begin
				scl_d = 1'b0;
				bc_d  = bc_inc;
				if (bc_inc[3]) held_d = shift_e;
			end
			ST_AK0: sda_d = !ack_e;
			ST_AK1: scl_d = 1'b1;
			ST_AK2: begin
				scl_d = 1'b0;
				done  = !ack_e;
			end
			ST_AK3: begin
				sda_d = 1'b1;
				done  = 1'b1;
			end
			default: ;
		endcase
		if (step_e != ST_TX_C || !bc_inc[3]) sda_out = sda_d;
	end

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			to_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_IDLE;
			bc_q       <= '0;
			shift_q    <= '0;
			wc_q       <= '0;
			ack_q      <= 1'b0;
			wait_act_q <= 1'b0;
			held_q     <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else if (q_pop) begin
			step_q     <= step_d;
			bc_q       <= bc_d;
			shift_q    <= shift_d;
			wc_q       <= wc_d;
			ack_q      <= ack_e;
			wait_act_q <= wait_act_e;
			held_q     <= held_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.scl_level   <= scl_d;
			res_q.sda_level   <= sda_out;
			res_q.ready_res   <= (step_d == ST_IDLE);
			res_q.done_res    <= done;
			res_q.rx_byte     <= held_d;
			res_q.ack_missing <= missing;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`I2CMBE_ASSERT_IMP(a_missing_is_done, clk, arst_n, out_valid_q && res_q.ack_missing, res_q.done_res, "ack_missing without done")
	`I2CMBE_ASSERT_IMP(a_done_goes_idle, clk, arst_n, out_valid_q && res_q.done_res, res_q.ready_res, "done without return to idle")

endmodule

// ===== sim/i2c_master_bit_engine_chk.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Watches the phase and result channels and the timeout register port. It
// keeps its own model of the bit sequencer, works out the line levels and
// flags due for each accepted phase word, and compares them in order with
// the result words. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        sda_sample,
	input  logic        cmd_valid,
	input  logic [2:0]  action,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        scl_level,
	input  logic        sda_level,
	input  logic        ready_res,
	input  logic        done_res,
	input  logic [7:0]  rx_byte,
	input  logic        ack_missing,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned timeouts
);
	import i2cmbe_pkg::*;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam int unsigned REPORT_MAX = 10;

	logic [7:0]  ack_limit;
	step_t       step;
	logic [3:0]  bit_cnt;
	logic [7:0]  shreg;
	logic [7:0]  high_cnt;
	logic        ack_sel;
	action_t     cur_act;
	logic [7:0]  rx_held;
	logic        scl_q;
	logic        sda_q;
	result_t     due_levels[$];
	int unsigned n_err;
	int unsigned n_chk;
	int unsigned n_tmo;

	function automatic result_t advance_phase(input logic smp, input logic cv,
			input logic [2:0] act, input logic [7:0] txb, input logic sack);
		result_t r;
		logic    fin;
		logic    miss;
		logic    hold;
		logic    last_bit;
		fin = 1'b0;
		miss = 1'b0;
		hold = 1'b0;
		last_bit = 1'b0;
		if (step == ST_IDLE && cv && act <= ACT_READ) begin
			cur_act = action_t'(act);
			bit_cnt = '0;
			case (action_t'(act))
				ACT_START: step = ST_START0;
				ACT_STOP:  step = ST_STOP0;
				ACT_WRITE: begin
					shreg = txb;
					step = ST_TX_A;
				end
				ACT_WAIT:  step = ST_WAIT0;
				default: begin
					ack_sel = sack;
					shreg = '0;
					sda_q = 1'b1;
					step = ST_RX_A;
				end
			endcase
		end
		case (step)
			ST_START0: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
				step = ST_START1;
			end
			ST_START1: begin
				sda_q = 1'b0;
				step = ST_START2;
			end
			ST_START2: begin
				scl_q = 1'b0;
				fin = 1'b1;
				step = ST_IDLE;
			end
			ST_STOP0: begin
				sda_q = 1'b0;
				step = ST_STOP1;
			end
			ST_STOP1: begin
				scl_q = 1'b1;
				step = ST_STOP2;
			end
			ST_STOP2: begin
				sda_q = 1'b1;
				fin = 1'b1;
				miss = (cur_act == ACT_WAIT);
				step = ST_IDLE;
			end
			ST_WAIT0: begin
				sda_q = 1'b1;
				high_cnt = '0;
				step = ST_WAIT1;
			end
			ST_WAIT1: begin
				scl_q = 1'b1;
				if (!smp)
					step = ST_WAIT2;
				else if (high_cnt >= ack_limit)
					step = ST_STOP0;
				else
					high_cnt = high_cnt + 8'd1;
			end
			ST_WAIT2: begin
				scl_q = 1'b0;
				fin = 1'b1;
				step = ST_IDLE;
			end
			ST_TX_A: begin
				sda_q = shreg[7];
				shreg = shreg << 1;
				step = ST_TX_B;
			end
			ST_TX_B: begin
				scl_q = 1'b1;
				step = ST_TX_C;
			end
			ST_TX_C: begin
				scl_q = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= BITS_PER_BYTE) begin
					// last data bit still on the line, released afterwards
					hold = 1'b1;
					last_bit = sda_q;
					sda_q = 1'b1;
					fin = 1'b1;
					step = ST_IDLE;
				end else begin
					step = ST_TX_A;
				end
			end
			ST_RX_A: begin
				scl_q = 1'b1;
				shreg = {shreg[6:0], smp};
				step = ST_RX_B;
			end
			ST_RX_B: begin
				scl_q = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= BITS_PER_BYTE) begin
					rx_held = shreg;
					step = ST_AK0;
				end else begin
					step = ST_RX_A;
				end
			end
			ST_AK0: begin
				sda_q = !ack_sel;
				step = ST_AK1;
			end
			ST_AK1: begin
				scl_q = 1'b1;
				step = ST_AK2;
			end
			ST_AK2: begin
				scl_q = 1'b0;
				if (ack_sel) begin
					step = ST_AK3;
				end else begin
					fin = 1'b1;
					step = ST_IDLE;
				end
			end
			ST_AK3: begin
				sda_q = 1'b1;
				fin = 1'b1;
				step = ST_IDLE;
			end
			default: step = ST_IDLE;
		endcase
		r.scl_level = scl_q;
		r.sda_level = hold ? last_bit : sda_q;
		r.ready_res = (step == ST_IDLE);
		r.done_res = fin;
		r.rx_byte = rx_held;
		r.ack_missing = miss;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			ack_limit = ACK_TIMEOUT_RST;
			step = ST_IDLE;
			bit_cnt = '0;
			shreg = '0;
			high_cnt = '0;
			ack_sel = 1'b0;
			cur_act = ACT_START;
			rx_held = '0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			due_levels.delete();
			n_err = 0;
			n_chk = 0;
			n_tmo = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
			timeouts <= 0;
		end else begin
			if (cfg_we)
				ack_limit = cfg_wdata;
			if (out_valid && out_ready) begin
				got = {scl_level, sda_level, ready_res, done_res, rx_byte, ack_missing};
				if (due_levels.size() == 0) begin
					n_err++;
					if (n_err <= REPORT_MAX)
						$display("result word with no phase word pending: %h", got);
				end else begin
					want = due_levels.pop_front();
					n_chk++;
					if (want.ack_missing)
						n_tmo++;
					if (got !== want) begin
						n_err++;
						if (n_err <= REPORT_MAX)
							$display({"word %0d mismatch (exp/got): scl %b/%b sda %b/%b ",
								"ready %b/%b done %b/%b rx %h/%h nack %b/%b"}, n_chk,
								want.scl_level, got.scl_level, want.sda_level, got.sda_level,
								want.ready_res, got.ready_res, want.done_res, got.done_res,
								want.rx_byte, got.rx_byte, want.ack_missing, got.ack_missing);
					end
				end
			end
			if (in_valid && in_ready)
				due_levels.push_back(advance_phase(sda_sample, cmd_valid, action, tx_byte,
					send_ack));
			errors <= n_err;
			pending <= due_levels.size();
			checked <= n_chk;
			timeouts <= n_tmo;
		end
	end

endmodule

// ===== sim/i2c_master_bit_engine_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives phase words shaped as I2C transfers (start, address write, ack wait,
// data writes and reads, stop) with stray commands and ignored commands mixed
// in, across several ack timeout settings and idle/stall patterns. The
// checker beside the engine predicts and compares every result word.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
	import i2cmbe_pkg::*;

	localparam int unsigned STAGE_WORDS = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = ACK_TIMEOUT_RST;
	logic        in_valid = 1'b0;
	logic        sda_sample = 1'b1;
	logic        cmd_valid = 1'b0;
	logic [2:0]  action = ACT_START;
	logic [7:0]  tx_byte = 8'h00;
	logic        send_ack = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        scl_level;
	logic        sda_level;
	logic        ready_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        ack_missing;
	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	int unsigned timeouts;

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	logic [7:0]  ack_limit = ACK_TIMEOUT_RST;
	int unsigned tmo_budget = 0;
	int unsigned words = 0;
	int unsigned settings = 1;

	i2c_master_bit_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.sda_sample(sda_sample), .cmd_valid(cmd_valid), .action(action),
		.tx_byte(tx_byte), .send_ack(send_ack),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_level(scl_level), .sda_level(sda_level), .ready_res(ready_res),
		.done_res(done_res), .rx_byte(rx_byte), .ack_missing(ack_missing)
	);

	i2c_master_bit_engine_chk chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.sda_sample(sda_sample), .cmd_valid(cmd_valid), .action(action),
		.tx_byte(tx_byte), .send_ack(send_ack),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_level(scl_level), .sda_level(sda_level), .ready_res(ready_res),
		.done_res(done_res), .rx_byte(rx_byte), .ack_missing(ack_missing),
		.errors(errors), .pending(pending), .checked(checked), .timeouts(timeouts)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic put_phase(input logic smp, input logic cv, input logic [2:0] act,
			input logic [7:0] txb, input logic sack);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sda_sample <= smp;
		cmd_valid <= cv;
		action <= act;
		tx_byte <= txb;
		send_ack <= sack;
		do @(posedge clk); while (!in_ready);
		words++;
	endtask

	// phase while a command runs: whatever command rides along is ignored
	task automatic busy_phase(input logic smp);
		put_phase(smp, 1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// phase while idle that starts nothing
	task automatic idle_phase();
		if ($urandom_range(0, 1))
			put_phase(1'($urandom), 1'b1,
				3'($urandom_range(int'(ACT_READ) + 1, (1 << $bits(action)) - 1)),
				8'($urandom), 1'($urandom));
		else
			put_phase(1'($urandom), 1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// data: byte written, or byte the target returns on a read
	// highs: high SDA samples seen by an ack wait before it goes low
	task automatic run_cmd(input action_t act, input logic [7:0] data, input logic sack,
			input int unsigned highs);
		int unsigned n;
		logic        fin;
		n = 0;
		fin = 1'b0;
		put_phase((act == ACT_READ) ? data[7] : 1'($urandom), 1'b1, act,
			(act == ACT_WRITE) ? data : 8'($urandom), sack);
		case (act)
			ACT_START, ACT_STOP: repeat (2) busy_phase(1'($urandom));
			ACT_WRITE: repeat (23) busy_phase(1'($urandom));
			ACT_READ: begin
				busy_phase(1'($urandom));
				for (n = 1; n < 8; n++) begin
					busy_phase(data[7 - n]);
					busy_phase(1'($urandom));
				end
				repeat (sack ? 4 : 3) busy_phase(1'($urandom));
			end
			default: begin
				while (!fin) begin
					if (n < highs) begin
						busy_phase(1'b1);
						if (n >= ack_limit) begin
							repeat (3) busy_phase(1'($urandom));
							fin = 1'b1;
						end
						n++;
					end else begin
						busy_phase(1'b0);
						busy_phase(1'($urandom));
						fin = 1'b1;
					end
				end
			end
		endcase
	endtask

	function automatic int unsigned ack_highs();
		if ($urandom_range(0, 3) == 0 && (ack_limit <= 20 || tmo_budget > 0)) begin
			if (ack_limit > 20)
				tmo_budget--;
			return ack_limit + 1 + $urandom_range(0, 2);
		end
		return $urandom_range(0, (ack_limit < 4) ? ack_limit : 4);
	endfunction

	task automatic set_timeout(input logic [7:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ack_limit = v;
		settings++;
	endtask

	task automatic transfer();
		run_cmd(ACT_START, 8'($urandom), 1'($urandom), 0);
		run_cmd(ACT_WRITE, 8'($urandom), 1'($urandom), 0);
		run_cmd(ACT_WAIT, 8'($urandom), 1'($urandom), ack_highs());
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1)) begin
				run_cmd(ACT_WRITE, 8'($urandom), 1'($urandom), 0);
				run_cmd(ACT_WAIT, 8'($urandom), 1'($urandom), ack_highs());
			end else begin
				run_cmd(ACT_READ, 8'($urandom), 1'($urandom), 0);
			end
		end
		if ($urandom_range(0, 3) == 0)
			idle_phase();
		run_cmd(ACT_STOP, 8'($urandom), 1'($urandom), 0);
	endtask

	initial begin
		int c;
		int stg;
		int unsigned base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle, unknown codes, both data extremes, acks, reads, timeout
		put_phase(1'b1, 1'b0, ACT_START, 8'h00, 1'b0);
		for (c = int'(ACT_READ) + 1; c < (1 << $bits(action)); c++)
			put_phase(1'b0, 1'b1, 3'(c), 8'hFF, 1'b1);
		run_cmd(ACT_START, 8'h00, 1'b0, 0);
		run_cmd(ACT_WRITE, 8'hFF, 1'b0, 0);
		run_cmd(ACT_WAIT, 8'h00, 1'b0, 3);
		run_cmd(ACT_WRITE, 8'h00, 1'b1, 0);
		run_cmd(ACT_WAIT, 8'h00, 1'b0, 0);
		run_cmd(ACT_READ, 8'hFF, 1'b1, 0);
		run_cmd(ACT_READ, 8'h00, 1'b0, 0);
		run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
		set_timeout(8'd1);
		run_cmd(ACT_WAIT, 8'h00, 1'b0, 1);
		run_cmd(ACT_WAIT, 8'h00, 1'b0, 2);

		for (stg = 0; stg < 4; stg++) begin
			case (stg)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					set_timeout(8'd255);
				end
				1: begin
					gap_pct = 73;
					stall_pct = 0;
					set_timeout(8'd1);
				end
				2: begin
					gap_pct = 0;
					stall_pct = 73;
					set_timeout(8'($urandom_range(2, 16)));
				end
				default: begin
					gap_pct = 38;
					stall_pct = 38;
					set_timeout(8'($urandom_range(1, 255)));
				end
			endcase
			tmo_budget = (stg == 0) ? 1 : 0;
			base = words;
			while (words - base < STAGE_WORDS) begin
				if ($urandom_range(0, 4) == 0) begin
					idle_phase();
					run_cmd(action_t'($urandom_range(0, int'(ACT_READ))), 8'($urandom),
						1'($urandom), ack_highs());
				end else begin
					transfer();
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("%0d phase words over %0d ack timeout settings, %0d results checked",
			words, settings, checked);
		$display("%0d ack timeouts with stop seen, %0d mismatches", timeouts, errors);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
